// ===== rtl/kmcb_pkg.sv =====
// kmcb_pkg: shared constants and codes for the keyed map with chained buckets.
// Used by kmcb_mod, keyed_map_chained_buckets and kmcb_chk. No dependencies.
package kmcb_pkg;

   localparam int BUCKETS      = 101;
   localparam int POOL_ENTRIES = 256;
   localparam int KEY_W        = 32;
   localparam int VAL_W        = 32;

   localparam int IDX_W   = $clog2(POOL_ENTRIES);
   localparam int PTR_W   = IDX_W + 1;
   localparam int CNT_W   = PTR_W;
   localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = KEY_W / DIGIT_W;
   localparam int DCNT_W  = $clog2(DIGITS);
   localparam int REM_W   = BKT_W + DIGIT_W;

   localparam logic [PTR_W-1:0] NIL_LINK = PTR_W'(POOL_ENTRIES);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

endpackage

// ===== rtl/kmcb_mod.sv =====
// kmcb_mod: iterative key modulo BUCKETS, one 4-bit digit per cycle, MSB first.
// Depends on kmcb_pkg.
module kmcb_mod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [kmcb_pkg::KEY_W-1:0]  key,
   output logic                        done,
   output logic [kmcb_pkg::BKT_W-1:0]  bucket
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [kmcb_pkg::DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic [kmcb_pkg::KEY_W-1:0]    shift_ff, shift_in;
   logic [kmcb_pkg::BKT_W-1:0]    rem_ff, rem_in;
   logic [kmcb_pkg::REM_W-1:0]    partial;
   logic [kmcb_pkg::REM_W-1:0]    sub;

   // partial < 16 * BUCKETS, so one multiple of BUCKETS is removed per step
   always_comb begin
      partial = {rem_ff, shift_ff[kmcb_pkg::KEY_W-1 -: kmcb_pkg::DIGIT_W]};
      sub     = '0;
      for (int k = 1; k < (1 << kmcb_pkg::DIGIT_W); k++) begin
         if (partial >= kmcb_pkg::REM_W'(k * kmcb_pkg::BUCKETS)) begin
            sub = kmcb_pkg::REM_W'(k * kmcb_pkg::BUCKETS);
         end
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      dcnt_in  = dcnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         dcnt_in  = '0;
         shift_in = key;
         rem_in   = '0;
      end else if (busy_ff) begin
         rem_in   = kmcb_pkg::BKT_W'(partial - sub);
         shift_in = shift_ff << kmcb_pkg::DIGIT_W;
         dcnt_in  = dcnt_ff + 1'b1;
         if (dcnt_ff == kmcb_pkg::DCNT_W'(kmcb_pkg::DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         dcnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         dcnt_ff <= dcnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;

endmodule

// ===== rtl/keyed_map_chained_buckets.sv =====
// keyed_map_chained_buckets: top level of the chained hash map.
// Depends on kmcb_pkg and kmcb_mod.
//
// Usage:
//   Request channel (req_valid/req_ready) carries operation, key and value:
//   insert or update, remove, lookup. Response channel (rsp_valid/rsp_ready)
//   returns found, data and status, exactly one response per request.
//   The bucket is key mod 101, computed by a shared digit-serial remainder
//   unit. The chain is then walked through one read port of the entry
//   memories, one entry per cycle. An insert of a new key also reads the
//   free stack. One request is in flight at a time; req_ready is high only
//   when the block is idle and the response has been taken.
//   Reset clears all bucket heads and refills the free stack at once via
//   valid bits; no clearing pass. When rsp_ready is low the response holds
//   and no new request is accepted.
module keyed_map_chained_buckets (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_operation,
   input  logic [kmcb_pkg::KEY_W-1:0]  req_key,
   input  logic [kmcb_pkg::VAL_W-1:0]  req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [kmcb_pkg::VAL_W-1:0]  rsp_data,
   output logic                        rsp_status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_HEAD,
      S_WALK,
      S_POP,
      S_RESP
   } state_type;

   state_type                    state_ff, state_in;
   logic [1:0]                   op_ff, op_in;
   logic [kmcb_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kmcb_pkg::VAL_W-1:0]   val_ff, val_in;
   logic [kmcb_pkg::BKT_W-1:0]   bucket_ff, bucket_in;
   logic [kmcb_pkg::IDX_W-1:0]   cur_ff, cur_in;
   logic [kmcb_pkg::PTR_W-1:0]   prev_ff, prev_in;
   logic [kmcb_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [kmcb_pkg::CNT_W-1:0]   free_cnt_ff, free_cnt_in;
   logic [kmcb_pkg::IDX_W-1:0]   pop_addr_ff, pop_addr_in;
   logic                         found_ff, found_in;
   logic [kmcb_pkg::VAL_W-1:0]   data_ff, data_in;
   logic                         status_ff, status_in;

   logic                         mod_start, mod_done;
   logic [kmcb_pkg::BKT_W-1:0]   mod_bucket;

   // bucket heads
   logic [kmcb_pkg::PTR_W-1:0]   head_mem [kmcb_pkg::BUCKETS];
   logic [kmcb_pkg::BUCKETS-1:0] head_vld_ff;
   logic                         head_re, head_we;
   logic [kmcb_pkg::PTR_W-1:0]   head_wdata;
   logic [kmcb_pkg::PTR_W-1:0]   head_q_ff;
   logic                         head_vld_q_ff;

   // entry pool
   logic [kmcb_pkg::KEY_W-1:0]   key_mem  [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::VAL_W-1:0]   val_mem  [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::PTR_W-1:0]   link_mem [kmcb_pkg::POOL_ENTRIES];
   logic                         ent_re;
   logic [kmcb_pkg::IDX_W-1:0]   ent_raddr;
   logic [kmcb_pkg::KEY_W-1:0]   key_q_ff;
   logic [kmcb_pkg::VAL_W-1:0]   val_q_ff;
   logic [kmcb_pkg::PTR_W-1:0]   link_q_ff;
   logic                         key_we, val_we, link_we;
   logic [kmcb_pkg::IDX_W-1:0]   key_waddr, val_waddr, link_waddr;
   logic [kmcb_pkg::PTR_W-1:0]   link_wdata;

   // free stack
   logic [kmcb_pkg::IDX_W-1:0]        fs_mem [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::POOL_ENTRIES-1:0] fs_vld_ff;
   logic                              fs_re, fs_we;
   logic [kmcb_pkg::IDX_W-1:0]        fs_raddr, fs_waddr, fs_wdata;
   logic [kmcb_pkg::IDX_W-1:0]        fs_q_ff;
   logic                              fs_vld_q_ff;

   logic                         do_hit, do_miss;
   logic [kmcb_pkg::PTR_W-1:0]   cur_ptr;
   logic [kmcb_pkg::IDX_W-1:0]   alloc_idx;

   kmcb_mod u_mod (
      .clock  (clock),
      .reset  (reset),
      .start  (mod_start),
      .key    (key_in),
      .done   (mod_done),
      .bucket (mod_bucket)
   );

   assign cur_ptr   = head_vld_q_ff ? head_q_ff : kmcb_pkg::NIL_LINK;
   assign alloc_idx = fs_vld_q_ff ? fs_q_ff : pop_addr_ff;

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      val_in      = val_ff;
      bucket_in   = bucket_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      head_in     = head_ff;
      free_cnt_in = free_cnt_ff;
      pop_addr_in = pop_addr_ff;
      found_in    = found_ff;
      data_in     = data_ff;
      status_in   = status_ff;
      mod_start   = 1'b0;
      head_re     = 1'b0;
      head_we     = 1'b0;
      head_wdata  = kmcb_pkg::NIL_LINK;
      ent_re      = 1'b0;
      ent_raddr   = cur_ff;
      key_we      = 1'b0;
      key_waddr   = alloc_idx;
      val_we      = 1'b0;
      val_waddr   = alloc_idx;
      link_we     = 1'b0;
      link_waddr  = alloc_idx;
      link_wdata  = head_ff;
      fs_re       = 1'b0;
      fs_raddr    = pop_addr_ff;
      fs_we       = 1'b0;
      fs_waddr    = free_cnt_ff[kmcb_pkg::IDX_W-1:0];
      fs_wdata    = cur_ff;
      do_hit      = 1'b0;
      do_miss     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_operation;
               key_in    = req_key;
               val_in    = req_value;
               found_in  = 1'b0;
               data_in   = '0;
               status_in = 1'b0;
               if (req_operation == kmcb_pkg::OP_INSERT ||
                   req_operation == kmcb_pkg::OP_REMOVE ||
                   req_operation == kmcb_pkg::OP_LOOKUP) begin
                  state_in = S_MOD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_MOD: begin
            if (mod_done) begin
               bucket_in = mod_bucket;
               head_re   = 1'b1;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            head_in = cur_ptr;
            prev_in = kmcb_pkg::NIL_LINK;
            if (cur_ptr >= kmcb_pkg::NIL_LINK) begin
               do_miss = 1'b1;
            end else begin
               cur_in    = cur_ptr[kmcb_pkg::IDX_W-1:0];
               ent_re    = 1'b1;
               ent_raddr = cur_ptr[kmcb_pkg::IDX_W-1:0];
               state_in  = S_WALK;
            end
         end
         S_WALK: begin
            if (key_q_ff == key_ff) begin
               do_hit = 1'b1;
            end else if (link_q_ff >= kmcb_pkg::NIL_LINK) begin
               do_miss = 1'b1;
            end else begin
               prev_in   = {1'b0, cur_ff};
               cur_in    = link_q_ff[kmcb_pkg::IDX_W-1:0];
               ent_re    = 1'b1;
               ent_raddr = link_q_ff[kmcb_pkg::IDX_W-1:0];
            end
         end
         S_POP: begin
            key_we     = 1'b1;
            val_we     = 1'b1;
            link_we    = 1'b1;
            link_wdata = head_ff;
            head_we    = 1'b1;
            head_wdata = {1'b0, alloc_idx};
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (do_hit) begin
         found_in = 1'b1;
         state_in = S_RESP;
         case (op_ff)
            kmcb_pkg::OP_INSERT: begin
               val_we    = 1'b1;
               val_waddr = cur_ff;
            end
            kmcb_pkg::OP_REMOVE: begin
               if (prev_ff >= kmcb_pkg::NIL_LINK) begin
                  head_we    = 1'b1;
                  head_wdata = link_q_ff;
               end else begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff[kmcb_pkg::IDX_W-1:0];
                  link_wdata = link_q_ff;
               end
               if (free_cnt_ff < kmcb_pkg::CNT_W'(kmcb_pkg::POOL_ENTRIES)) begin
                  fs_we       = 1'b1;
                  free_cnt_in = free_cnt_ff + 1'b1;
               end
            end
            default: begin
               data_in = val_q_ff;
            end
         endcase
      end

      if (do_miss) begin
         state_in = S_RESP;
         if (op_ff == kmcb_pkg::OP_INSERT) begin
            if (free_cnt_ff == '0) begin
               status_in = 1'b1;
            end else begin
               free_cnt_in = free_cnt_ff - 1'b1;
               pop_addr_in = kmcb_pkg::IDX_W'(free_cnt_ff - 1'b1);
               fs_re       = 1'b1;
               fs_raddr    = kmcb_pkg::IDX_W'(free_cnt_ff - 1'b1);
               state_in    = S_POP;
            end
         end
      end

      mod_start = (state_ff == S_IDLE) && req_valid && (state_in == S_MOD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         free_cnt_ff <= kmcb_pkg::CNT_W'(kmcb_pkg::POOL_ENTRIES);
      end else begin
         state_ff    <= state_in;
         free_cnt_ff <= free_cnt_in;
      end
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      bucket_ff   <= bucket_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      head_ff     <= head_in;
      pop_addr_ff <= pop_addr_in;
      found_ff    <= found_in;
      data_ff     <= data_in;
      status_ff   <= status_in;
   end

   // valid bits: a cleared bit reads as the reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= '0;
         fs_vld_ff   <= '0;
      end else begin
         if (head_we) begin
            head_vld_ff[bucket_ff] <= 1'b1;
         end
         if (fs_we) begin
            fs_vld_ff[fs_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[bucket_ff] <= head_wdata;
      end
      if (head_re) begin
         head_q_ff     <= head_mem[mod_bucket];
         head_vld_q_ff <= head_vld_ff[mod_bucket];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      if (ent_re) begin
         key_q_ff <= key_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_ff;
      end
      if (ent_re) begin
         val_q_ff <= val_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (ent_re) begin
         link_q_ff <= link_mem[ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_waddr] <= fs_wdata;
      end
      if (fs_re) begin
         fs_q_ff     <= fs_mem[fs_raddr];
         fs_vld_q_ff <= fs_vld_ff[fs_raddr];
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_found  = found_ff;
   assign rsp_data   = data_ff;
   assign rsp_status = status_ff;

endmodule

// ===== rtl/kmcb_chk.sv =====
// kmcb_chk: port-level assertions for keyed_map_chained_buckets, bound below.
// Depends on kmcb_pkg.
module kmcb_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [kmcb_pkg::VAL_W-1:0]  rsp_data,
   input logic                        rsp_status
);

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after an item was accepted");

   a_fail_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_status && rsp_found))
      else $error("pool-exhausted status on a found key");

   a_data_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data != '0) |-> rsp_found && !rsp_status)
      else $error("nonzero data without a hit");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)
         && $stable(rsp_found) && $stable(rsp_status))
      else $error("response changed while stalled");

endmodule

bind keyed_map_chained_buckets kmcb_chk u_kmcb_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_found  (rsp_found),
   .rsp_data   (rsp_data),
   .rsp_status (rsp_status)
);

// ===== bench/keyed_map_chained_buckets_tb.sv =====
// keyed_map_chained_buckets_tb: self-checking bench for the chained hash map.
// Runs directed, pool-exhaustion and random traffic against a local map model.
// Depends on kmcb_pkg and keyed_map_chained_buckets.
`timescale 1ns / 1ps

module keyed_map_chained_buckets_tb;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CLK_HALF       = 10;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TAIL_CYCLES    = 300;
   localparam int RECUR_KEYS     = 48;

   typedef struct packed {
      logic                       found;
      logic [kmcb_pkg::VAL_W-1:0] data;
      logic                       status;
   } map_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_operation = kmcb_pkg::OP_LOOKUP;
   logic [kmcb_pkg::KEY_W-1:0] req_key = '0;
   logic [kmcb_pkg::VAL_W-1:0] req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic [kmcb_pkg::VAL_W-1:0] rsp_data;
   logic                       rsp_status;

   // map model state
   logic [kmcb_pkg::PTR_W-1:0] head_of   [kmcb_pkg::BUCKETS];
   logic [kmcb_pkg::KEY_W-1:0] slot_key  [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::VAL_W-1:0] slot_val  [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::PTR_W-1:0] slot_next [kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::IDX_W-1:0] free_slots[kmcb_pkg::POOL_ENTRIES];
   logic [kmcb_pkg::CNT_W-1:0] free_total;

   map_result_type             expected_results[$];
   int                         fail_count = 0;
   int                         sender_idle_pct = 0;
   int                         receiver_stall_pct = 0;
   int                         quiet_cycles = 0;
   logic [kmcb_pkg::KEY_W-1:0] recurring_keys[RECUR_KEYS];
   logic [kmcb_pkg::KEY_W-1:0] fill_keys[kmcb_pkg::POOL_ENTRIES];

   keyed_map_chained_buckets dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_found     (rsp_found),
      .rsp_data      (rsp_data),
      .rsp_status    (rsp_status)
   );

   always #CLK_HALF clock = ~clock;

   function automatic void map_clear();
      for (int i = 0; i < kmcb_pkg::BUCKETS; i++) head_of[i] = kmcb_pkg::NIL_LINK;
      for (int i = 0; i < kmcb_pkg::POOL_ENTRIES; i++) begin
         slot_key[i]   = '0;
         slot_val[i]   = '0;
         slot_next[i]  = kmcb_pkg::NIL_LINK;
         free_slots[i] = kmcb_pkg::IDX_W'(i);
      end
      free_total = kmcb_pkg::CNT_W'(kmcb_pkg::POOL_ENTRIES);
   endfunction

   // walk a chain; on a hit prior holds the predecessor or NIL_LINK at the head
   function automatic logic [kmcb_pkg::PTR_W-1:0] chain_search(
         input int b, input logic [kmcb_pkg::KEY_W-1:0] key,
         output logic [kmcb_pkg::PTR_W-1:0] prior);
      logic [kmcb_pkg::PTR_W-1:0] cur;
      cur   = head_of[b];
      prior = kmcb_pkg::NIL_LINK;
      for (int steps = 0; steps < kmcb_pkg::POOL_ENTRIES; steps++) begin
         if (cur >= kmcb_pkg::NIL_LINK) break;
         if (slot_key[cur[kmcb_pkg::IDX_W-1:0]] == key) return cur;
         prior = cur;
         cur   = slot_next[cur[kmcb_pkg::IDX_W-1:0]];
      end
      prior = kmcb_pkg::NIL_LINK;
      return kmcb_pkg::NIL_LINK;
   endfunction

   function automatic map_result_type map_apply(input logic [1:0] op,
         input logic [kmcb_pkg::KEY_W-1:0] key, input logic [kmcb_pkg::VAL_W-1:0] val);
      map_result_type             r;
      int                         b;
      logic [kmcb_pkg::PTR_W-1:0] hit;
      logic [kmcb_pkg::PTR_W-1:0] prior;
      logic [kmcb_pkg::IDX_W-1:0] e;
      r   = '0;
      b   = int'(key % 32'(kmcb_pkg::BUCKETS));
      hit = kmcb_pkg::NIL_LINK;
      case (op)
         kmcb_pkg::OP_INSERT: begin
            hit = chain_search(b, key, prior);
            if (hit != kmcb_pkg::NIL_LINK) begin
               slot_val[hit[kmcb_pkg::IDX_W-1:0]] = val;
               r.found = 1'b1;
            end else if (free_total == 0) begin
               r.status = 1'b1;
            end else begin
               free_total   = free_total - 1'b1;
               e            = free_slots[free_total[kmcb_pkg::IDX_W-1:0]];
               slot_key[e]  = key;
               slot_val[e]  = val;
               slot_next[e] = head_of[b];
               head_of[b]   = kmcb_pkg::PTR_W'(e);
            end
         end
         kmcb_pkg::OP_REMOVE: begin
            hit = chain_search(b, key, prior);
            if (hit != kmcb_pkg::NIL_LINK) begin
               if (prior == kmcb_pkg::NIL_LINK) begin
                  head_of[b] = slot_next[hit[kmcb_pkg::IDX_W-1:0]];
               end else begin
                  slot_next[prior[kmcb_pkg::IDX_W-1:0]] =
                     slot_next[hit[kmcb_pkg::IDX_W-1:0]];
               end
               slot_next[hit[kmcb_pkg::IDX_W-1:0]] = kmcb_pkg::NIL_LINK;
               if (free_total < kmcb_pkg::POOL_ENTRIES) begin
                  free_slots[free_total[kmcb_pkg::IDX_W-1:0]] = hit[kmcb_pkg::IDX_W-1:0];
                  free_total = free_total + 1'b1;
               end
               r.found = 1'b1;
            end
         end
         kmcb_pkg::OP_LOOKUP: begin
            hit = chain_search(b, key, prior);
            if (hit != kmcb_pkg::NIL_LINK) begin
               r.found = 1'b1;
               r.data  = slot_val[hit[kmcb_pkg::IDX_W-1:0]];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [kmcb_pkg::KEY_W-1:0] key,
                            input logic [kmcb_pkg::VAL_W-1:0] val);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_key       <= key;
      req_value     <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_results.push_back(map_apply(op, key, val));
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int snd, input int rcv);
      sender_idle_pct    = snd;
      receiver_stall_pct = rcv;
   endtask

   task automatic test_directed();
      set_idling(0, 0);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
      send_item(kmcb_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(kmcb_pkg::OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
      // three keys sharing bucket zero
      send_item(kmcb_pkg::OP_INSERT, 32'd101, 32'h5A5A_5A5A);
      send_item(kmcb_pkg::OP_INSERT, 32'd202, 32'hA5A5_A5A5);
      send_item(kmcb_pkg::OP_LOOKUP, 32'd101, 32'h0000_0000);
      send_item(kmcb_pkg::OP_REMOVE, 32'd101, 32'hFFFF_FFFF);
      send_item(kmcb_pkg::OP_LOOKUP, 32'd202, 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, 32'd101, 32'h0000_0000);
      send_item(kmcb_pkg::OP_REMOVE, 32'd202, 32'h0000_0000);
      send_item(kmcb_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
      send_item(kmcb_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0001);
      send_item(kmcb_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_item(kmcb_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0000);
      wait_idle();
   endtask

   task automatic test_pool_exhaustion();
      logic [kmcb_pkg::KEY_W-1:0] offset;
      logic [kmcb_pkg::KEY_W-1:0] tmp;
      int                         j;
      set_idling(34, 34);
      offset = 32'(101) * 32'($urandom_range(0, 42_000_000));
      // eight long chains, distinct keys
      for (int i = 0; i < kmcb_pkg::POOL_ENTRIES; i++) begin
         fill_keys[i] = offset + 32'(i * 101 + i % 8);
         send_item(kmcb_pkg::OP_INSERT, fill_keys[i], $urandom());
      end
      send_item(kmcb_pkg::OP_LOOKUP, fill_keys[0], 32'h0000_0000);
      send_item(kmcb_pkg::OP_LOOKUP, fill_keys[kmcb_pkg::POOL_ENTRIES-1], 32'h0000_0000);
      send_item(kmcb_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(kmcb_pkg::OP_INSERT, offset + 32'd7, $urandom());
      send_item(kmcb_pkg::OP_INSERT, fill_keys[100], 32'hFFFF_FFFF);
      send_item(kmcb_pkg::OP_LOOKUP, fill_keys[100], 32'h0000_0000);
      for (int i = kmcb_pkg::POOL_ENTRIES - 1; i > 0; i--) begin
         j            = $urandom_range(0, i);
         tmp          = fill_keys[i];
         fill_keys[i] = fill_keys[j];
         fill_keys[j] = tmp;
      end
      for (int i = 0; i < kmcb_pkg::POOL_ENTRIES; i++) begin
         send_item(kmcb_pkg::OP_REMOVE, fill_keys[i], $urandom());
         if (i == kmcb_pkg::POOL_ENTRIES / 2) begin
            send_item(kmcb_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
            send_item(kmcb_pkg::OP_LOOKUP, fill_keys[0], 32'h0000_0000);
            send_item(kmcb_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
         end
      end
      send_item(kmcb_pkg::OP_REMOVE, fill_keys[3], 32'h0000_0000);
      wait_idle();
   endtask

   task automatic run_random_phase(input int count, input int snd, input int rcv);
      int                         pick;
      logic [1:0]                 op;
      logic [kmcb_pkg::KEY_W-1:0] key;
      set_idling(snd, rcv);
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 40) op = kmcb_pkg::OP_INSERT;
         else if (pick < 65) op = kmcb_pkg::OP_REMOVE;
         else if (pick < 95) op = kmcb_pkg::OP_LOOKUP;
         else op = OP_UNUSED;
         if ($urandom_range(99) < 75) key = recurring_keys[$urandom_range(0, RECUR_KEYS - 1)];
         else key = $urandom();
         send_item(op, key, $urandom());
         if ($urandom_range(39) == 0) wait_idle();
      end
      wait_idle();
   endtask

   task automatic test_random();
      for (int i = 0; i < RECUR_KEYS; i++) begin
         if (i < RECUR_KEYS / 2) recurring_keys[i] = $urandom();
         else recurring_keys[i] = 32'(101) * 32'($urandom_range(0, 1000)) +
                                  32'($urandom_range(0, 3));
      end
      run_random_phase(125, 0, 0);
      run_random_phase(125, 68, 0);
      run_random_phase(125, 0, 68);
      run_random_phase(125, 34, 34);
   endtask

   always @(posedge clock) begin : rsp_check
      map_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result item: found=%0d data=%h status=%0d",
                   rsp_found, rsp_data, rsp_status);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_found);
               fail_count++;
            end
            if (rsp_data !== want.data) begin
               $error("data: expected %h, got %h", want.data, rsp_data);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("keyed_map_chained_buckets_tb NOT OK");
            $finish;
         end
      end
   end

   initial begin
      map_clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_exhaustion();
      test_random();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d result items never arrived", expected_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("keyed_map_chained_buckets_tb OK");
      end else begin
         $display("keyed_map_chained_buckets_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/kmcb_pkg.sv
rtl/kmcb_mod.sv
rtl/keyed_map_chained_buckets.sv
rtl/kmcb_chk.sv
bench/keyed_map_chained_buckets_tb.sv
